// ===== rtl/miss_overlap_and_bank_conflict_timer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the miss overlap and bank conflict timer
// Shared helpers that wrap concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef MISS_OVERLAP_AND_BANK_CONFLICT_TIMER_DEFINES_SVH
`define MISS_OVERLAP_AND_BANK_CONFLICT_TIMER_DEFINES_SVH

// Same-cycle implication.
`define MOT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer assertion failed");

// Next-cycle implication.
`define MOT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer assertion failed");

`endif

// ===== rtl/mot_pkg.sv =====
// ----------------------------------------------------------------------------
// mot_pkg
// Types and constants shared by the miss overlap and bank conflict timer.
// ----------------------------------------------------------------------------
package mot_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int MAX_BANKS_DEF   = 16;
   localparam int LINE_SHIFT_DEF  = 6;

   localparam int CYC_W    = 48;
   localparam int LAT_W    = 16;
   localparam int EFF_W    = 17;
   localparam int SLOTS_W  = 7;
   localparam int BANKS_W  = 5;
   localparam int STALL_W  = 16;
   localparam int DIVR_W   = 8;
   localparam int STEPS_W  = 6;

   localparam logic [1:0] REG_MISS_SLOTS = 2'd0;
   localparam logic [1:0] REG_NUM_BANKS  = 2'd1;
   localparam logic [1:0] REG_BUSY_TIME  = 2'd2;

   localparam logic FUNC_ACCESS = 1'b0;
   localparam logic FUNC_PROBE  = 1'b1;

   typedef struct packed {
      logic                start;
      logic [STEPS_W-1:0]  steps;
      logic [CYC_W-1:0]    dividend;
      logic [DIVR_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [CYC_W-1:0]    quotient;
      logic [DIVR_W-1:0]   remainder;
   } div_rsp_type;

endpackage

// ===== rtl/miss_overlap_and_bank_conflict_timer.sv =====
// ----------------------------------------------------------------------------
// miss_overlap_and_bank_conflict_timer
// Tracks completion cycles of outstanding misses, discounts overlapping
// misses and adds bank conflict stalls, one beat at a time.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents
//   req_     in   tuser: func; tdata: item cycle, address, downstream latency,
//                 downstream_completion
//   rsp_     out  tdata: effective_latency through stall cycles, one beat per
//                 request
//   csr_     in   register writes: miss_slots, number of banks, bank busy time
//
// A request sweeps the table for expiry (one RAM read per cycle), then
// selects a bank on the divider when the conflict model is on, then divides
// for the overlap discount when a miss overlaps peers, then sequences the
// insert and the result. The single divider and the single RAM read port
// serve these steps in turn. Reset is synchronous, clears the table count,
// the bank touched flags and the bank and busy-time registers, and sets
// miss_slots to 16; the table RAM and the bank marks are not cleared. A result
// beat holds until rsp_tready, and no new request is taken until it leaves.
//
module miss_overlap_and_bank_conflict_timer
   import mot_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int MAX_BANKS   = MAX_BANKS_DEF,
   parameter int LINE_SHIFT  = LINE_SHIFT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [47:0] item cycle, [95:48] address, [111:96] downstream latency,
   // [159:112] downstream_completion
   input  logic [159:0] req_tdata,
   // [0] func
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [16:0] effective_latency, [64:17] completion, [71:65] outstanding_count,
   // [72] accept flag, [73] overlapped, [74] bank_conflict,
   // [90:75] stall cycles, [95:91] zero
   output logic [95:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   `include "miss_overlap_and_bank_conflict_timer_defines.svh"

   localparam int CNT_W = ($clog2(MAX_ENTRIES + 1) > SLOTS_W) ?
                          $clog2(MAX_ENTRIES + 1) : SLOTS_W;
   localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int BW    = $clog2(MAX_BANKS);
   localparam logic [CYC_W-1:0] CYC_MAX = '1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_EXP    = 11'b00000000010,
      ST_PREP   = 11'b00000000100,
      ST_BDIV   = 11'b00000001000,
      ST_BADD   = 11'b00000010000,
      ST_BUPD   = 11'b00000100000,
      ST_DECIDE = 11'b00001000000,
      ST_LDIV   = 11'b00010000000,
      ST_INS    = 11'b00100000000,
      ST_FIN    = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   function automatic logic [CYC_W-1:0] sat_add(input logic [CYC_W-1:0] a,
                                                input logic [CYC_W-1:0] b);
      logic [CYC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CYC_W] ? CYC_MAX : s[CYC_W-1:0];
   endfunction

   state_type state_ff, state_in;

   // Configuration registers.
   logic [SLOTS_W-1:0] slots_ff, slots_in;
   logic [BANKS_W-1:0] banks_ff, banks_in;
   logic [STALL_W-1:0] bstall_ff, bstall_in;

   // Latched request.
   logic               func_ff, func_in;
   logic [CYC_W-1:0]   now_ff, now_in;
   logic [CYC_W-1:0]   addr_ff, addr_in;
   logic [LAT_W-1:0]   lat_ff, lat_in;
   logic [CYC_W-1:0]   dcomp_ff, dcomp_in;

   // Table bookkeeping.
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;
   logic               pend_ff, pend_in;

   // Bank state.
   logic [CYC_W-1:0]   mark_ff [MAX_BANKS];
   logic [CYC_W-1:0]   mark_in [MAX_BANKS];
   logic [MAX_BANKS-1:0] touched_ff, touched_in;
   logic [BW-1:0]      bank_ff, bank_in;
   logic [CYC_W-1:0]   busy_ff, busy_in;

   // Working results.
   logic [CYC_W-1:0]   comp_ff, comp_in;
   logic [31:0]        stall_ff, stall_in;
   logic [LAT_W-1:0]   eff_ff, eff_in;
   logic               ovl_ff, ovl_in;
   logic [95:0]        out_ff, out_in;

   logic               ram_we;
   logic [IW-1:0]      ram_waddr;
   logic [CYC_W-1:0]   ram_wdata;
   logic [CYC_W-1:0]   ram_rdata;
   logic               issue;

   div_req_type        dreq;
   div_rsp_type        drsp;

   logic [7:0]         banks_eff;
   logic [CNT_W-1:0]   cap;
   logic [CNT_W-1:0]   peers;
   logic               ins_ok;
   logic [CYC_W-1:0]   diff;

   mot_ram #(.WIDTH(CYC_W), .DEPTH(MAX_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   mot_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = out_ff;

   always_comb begin
      // Bank count beyond the array size acts as the array size.
      banks_eff = ({3'b000, banks_ff} > 8'(MAX_BANKS)) ? 8'(MAX_BANKS)
                                                       : {3'b000, banks_ff};
      cap    = (slots_ff != '0) ? CNT_W'(slots_ff - 1'b1) : '0;
      peers  = (count_ff > cap) ? cap : count_ff;
      ins_ok = (lat_ff != '0) && (count_ff < CNT_W'(slots_ff)) &&
               (count_ff < CNT_W'(MAX_ENTRIES));
      diff   = busy_ff - now_ff;
      issue  = rd_idx_ff < count_ff;
   end

   always_comb begin
      state_in   = state_ff;
      slots_in   = slots_ff;
      banks_in   = banks_ff;
      bstall_in  = bstall_ff;
      func_in    = func_ff;
      now_in     = now_ff;
      addr_in    = addr_ff;
      lat_in     = lat_ff;
      dcomp_in   = dcomp_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      kept_in    = kept_ff;
      pend_in    = 1'b0;
      mark_in    = mark_ff;
      touched_in = touched_ff;
      bank_in    = bank_ff;
      busy_in    = busy_ff;
      comp_in    = comp_ff;
      stall_in   = stall_ff;
      eff_in     = eff_ff;
      ovl_in     = ovl_ff;
      out_in     = out_ff;
      ram_we     = 1'b0;
      ram_waddr  = kept_ff[IW-1:0];
      ram_wdata  = ram_rdata;
      dreq       = '0;

      if (csr_we) begin
         case (csr_index)
            REG_MISS_SLOTS: slots_in  = csr_wdata[SLOTS_W-1:0];
            REG_NUM_BANKS:  banks_in  = csr_wdata[BANKS_W-1:0];
            REG_BUSY_TIME:  bstall_in = csr_wdata[STALL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_tuser;
               now_in    = req_tdata[47:0];
               addr_in   = req_tdata[95:48];
               lat_in    = req_tdata[111:96];
               dcomp_in  = req_tdata[159:112];
               rd_idx_in = '0;
               kept_in   = '0;
               stall_in  = '0;
               ovl_in    = 1'b0;
               eff_in    = req_tdata[111:96];
               state_in  = ST_EXP;
            end
         end
         ST_EXP: begin
            // Read runs one entry ahead of the compare; survivors are
            // written back compacted at the kept pointer.
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff && (ram_rdata >= now_ff)) begin
               ram_we  = 1'b1;
               kept_in = kept_ff + 1'b1;
            end
            if (!issue && !pend_ff) begin
               count_in = kept_ff;
               state_in = (func_ff == FUNC_PROBE) ? ST_FIN : ST_PREP;
            end
         end
         ST_PREP: begin
            comp_in = (dcomp_ff > now_ff) ? dcomp_ff : sat_add(now_ff, CYC_W'(lat_ff));
            if ((banks_ff > BANKS_W'(1)) && (bstall_ff != '0)) begin
               dreq.start    = 1'b1;
               dreq.steps    = STEPS_W'(CYC_W - LINE_SHIFT);
               dreq.dividend = (addr_ff >> LINE_SHIFT) << LINE_SHIFT;
               dreq.divisor  = banks_eff;
               state_in      = ST_BDIV;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_BDIV: begin
            if (drsp.done) begin
               bank_in  = drsp.remainder[BW-1:0];
               state_in = ST_BADD;
            end
         end
         ST_BADD: begin
            busy_in  = sat_add(mark_ff[bank_ff], CYC_W'(bstall_ff));
            state_in = ST_BUPD;
         end
         ST_BUPD: begin
            if (!touched_ff[bank_ff]) begin
               touched_in[bank_ff] = 1'b1;
               mark_in[bank_ff]    = now_ff;
            end else if (now_ff < busy_ff) begin
               stall_in         = diff[31:0];
               mark_in[bank_ff] = busy_ff;
            end else begin
               mark_in[bank_ff] = now_ff;
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (ins_ok && (peers != '0)) begin
               dreq.start    = 1'b1;
               dreq.steps    = STEPS_W'(LAT_W);
               dreq.dividend = {lat_ff, {(CYC_W - LAT_W){1'b0}}};
               dreq.divisor  = DIVR_W'(peers + 1'b1);
               state_in      = ST_LDIV;
            end else if (ins_ok) begin
               state_in = ST_INS;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_LDIV: begin
            if (drsp.done) begin
               eff_in   = (drsp.quotient[LAT_W-1:0] == '0) ? LAT_W'(1)
                                                           : drsp.quotient[LAT_W-1:0];
               ovl_in   = 1'b1;
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[IW-1:0];
            ram_wdata = comp_ff;
            count_in  = count_ff + 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            out_in = '0;
            out_in[71:65] = count_ff[SLOTS_W-1:0];
            out_in[72]    = count_ff < CNT_W'(slots_ff);
            if (func_ff == FUNC_ACCESS) begin
               out_in[16:0]  = EFF_W'({1'b0, eff_ff} + stall_ff[EFF_W-1:0]);
               out_in[64:17] = comp_ff;
               out_in[73]    = ovl_ff;
               out_in[74]    = stall_ff != '0;
               out_in[90:75] = stall_ff[STALL_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         slots_ff   <= SLOTS_W'(16);
         banks_ff   <= '0;
         bstall_ff  <= '0;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         touched_ff <= '0;
      end else begin
         state_ff   <= state_in;
         slots_ff   <= slots_in;
         banks_ff   <= banks_in;
         bstall_ff  <= bstall_in;
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         touched_ff <= touched_in;
      end
      func_ff   <= func_in;
      now_ff    <= now_in;
      addr_ff   <= addr_in;
      lat_ff    <= lat_in;
      dcomp_ff  <= dcomp_in;
      rd_idx_ff <= rd_idx_in;
      kept_ff   <= kept_in;
      mark_ff   <= mark_in;
      bank_ff   <= bank_in;
      busy_ff   <= busy_in;
      comp_ff   <= comp_in;
      stall_ff  <= stall_in;
      eff_ff    <= eff_in;
      ovl_ff    <= ovl_in;
      out_ff    <= out_in;
   end

   // The sequencer never offers a request slot while a result is pending.
   `MOT_ASSERT_IMPL(a_hs_excl, clock, reset, req_tready, !rsp_tvalid)
   // A delivered result returns the block to the idle state.
   `MOT_ASSERT_NEXT(a_back_idle, clock, reset, rsp_tvalid && rsp_tready, req_tready)
   // An accepted request always starts with the expiry sweep.
   `MOT_ASSERT_NEXT(a_accept_exp, clock, reset, req_tvalid && req_tready, state_ff == ST_EXP)
   // The table never holds more entries than it has rows.
   `MOT_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))

endmodule

// ===== rtl/mot_ram.sv =====
// ----------------------------------------------------------------------------
// mot_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mot_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/mot_div.sv =====
// ----------------------------------------------------------------------------
// mot_div
// Restoring divider, one quotient bit per cycle, shared by the bank select
// and the overlap discount.
// ----------------------------------------------------------------------------
module mot_div
   import mot_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEPS_W-1:0] cnt_ff, cnt_in;
   logic [CYC_W-1:0]   quo_ff, quo_in;
   logic [DIVR_W-1:0]  rem_ff, rem_in;
   logic [DIVR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVR_W:0]    trial;
   logic               fits;

   // The dividend arrives left-aligned so only the requested number of
   // steps is run; the quotient then sits in the low bits.
   always_comb begin
      trial   = {rem_ff, quo_ff[CYC_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIVR_W'(trial - {1'b0, dsr_ff}) : trial[DIVR_W-1:0];
         quo_in = {quo_ff[CYC_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEPS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== test/miss_overlap_and_bank_conflict_timer_tb.sv =====
// ----------------------------------------------------------------------------
// Miss overlap and bank conflict timer testbench
// Drives access and probe beats through the request stream, predicts each
// response beat with a behavioral copy of the tracker, and compares every
// field. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module miss_overlap_and_bank_conflict_timer_tb;
   import mot_pkg::*;

   localparam int NUM_SLOTS  = 64;
   localparam int NUM_BANKS  = 16;
   localparam int WATCHDOG   = 200000;
   localparam logic [47:0] CYC_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [16:0] eff_lat;
      logic [47:0] comp;
      logic [6:0]  count;
      logic        accept;
      logic        ovl;
      logic        conflict;
      logic [15:0] stall;
   } timing_type;

   typedef struct {
      logic        func;
      logic [47:0] now;
      logic [47:0] addr;
      logic [15:0] lat;
      logic [47:0] dcomp;
   } access_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [159:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;

   miss_overlap_and_bank_conflict_timer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state: the outstanding-miss table, bank marks and registers.
   logic [47:0] miss_done_at [NUM_SLOTS];
   int unsigned live_misses;
   logic [47:0] bank_mark [NUM_BANKS];
   logic        bank_used [NUM_BANKS];
   int unsigned slots_reg, banks_reg, stall_reg;

   timing_type pending_timing [$];
   int      fail_count;
   int      idle_cycles;
   bit      hold_rsp;    // long receiver hold-off for the back-pressure phase
   bit      hold_done;   // the long hold-off has been started once

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? CYC_MAX : s[47:0];
   endfunction

   function automatic void reset_tracker();
      live_misses = 0;
      for (int i = 0; i < NUM_BANKS; i++) begin
         bank_mark[i] = '0;
         bank_used[i] = 1'b0;
      end
      slots_reg = 16;
      banks_reg = 0;
      stall_reg = 0;
   endfunction

   // Computes the response for one beat and updates the tracker state.
   function automatic timing_type track_miss(access_type a);
      timing_type  r;
      int unsigned kept, peers, cap, bk, eff, stall, nb;
      logic [47:0] busy;
      r = '0;
      stall = 0;
      kept = 0;
      // Expiry keeps entries that complete at or after the current cycle.
      for (int i = 0; i < live_misses; i++) begin
         if (miss_done_at[i] >= a.now) begin
            miss_done_at[kept] = miss_done_at[i];
            kept++;
         end
      end
      live_misses = kept;
      if (a.func == FUNC_PROBE) begin
         r.count  = 7'(kept);
         r.accept = kept < slots_reg;
         return r;
      end
      if (banks_reg > 1 && stall_reg > 0) begin
         nb = (banks_reg > NUM_BANKS) ? NUM_BANKS : banks_reg;
         bk = 32'((a.addr >> 6) % 48'(nb));
         if (!bank_used[bk]) begin
            bank_used[bk] = 1'b1;
            bank_mark[bk] = a.now;
         end else begin
            busy = sat_sum(bank_mark[bk], 48'(stall_reg));
            if (a.now < busy) begin
               stall = 32'(busy - a.now);
               bank_mark[bk] = busy;
            end else begin
               bank_mark[bk] = a.now;
            end
         end
      end
      r.comp = (a.dcomp > a.now) ? a.dcomp : sat_sum(a.now, 48'(a.lat));
      eff = 32'(a.lat);
      if (a.lat > 0 && live_misses < slots_reg && live_misses < NUM_SLOTS) begin
         cap = (slots_reg > 0) ? slots_reg - 1 : 0;
         peers = (kept > cap) ? cap : kept;
         if (peers > 0) begin
            eff = 32'(a.lat) / (1 + peers);
            if (eff < 1) eff = 1;
            r.ovl = 1'b1;
         end
         miss_done_at[live_misses] = r.comp;
         live_misses++;
      end
      r.eff_lat  = 17'(eff + stall);
      r.count    = 7'(live_misses);
      r.accept   = live_misses < slots_reg;
      r.conflict = stall > 0;
      r.stall    = 16'(stall);
      return r;
   endfunction

   function automatic timing_type unpack_rsp(logic [95:0] d);
      timing_type r;
      r.eff_lat  = d[16:0];
      r.comp     = d[64:17];
      r.count    = d[71:65];
      r.accept   = d[72];
      r.ovl      = d[73];
      r.conflict = d[74];
      r.stall    = d[90:75];
      return r;
   endfunction

   // Receiver: a stall pattern of its own, plus the long hold-off on request.
   initial begin
      int phase;
      phase = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_rsp) rsp_tready <= 1'b0;
         else if ((phase / 200) % 3 == 0) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Response checker and watchdog, both sampled at the rising edge.
   initial begin
      timing_type got, want;
      fail_count = 0;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = unpack_rsp(rsp_tdata);
            if (pending_timing.size() == 0) begin
               $display("%0t: response beat with nothing expected: %h", $time, got);
               fail_count++;
            end else begin
               want = pending_timing.pop_front();
               if (got.eff_lat !== want.eff_lat)
                  $display("%0t: effective_latency exp %0d got %0d", $time,
                           want.eff_lat, got.eff_lat);
               if (got.comp !== want.comp)
                  $display("%0t: completion exp %h got %h", $time,
                           want.comp, got.comp);
               if (got.count !== want.count)
                  $display("%0t: outstanding_count exp %0d got %0d", $time,
                           want.count, got.count);
               if (got.accept !== want.accept)
                  $display("%0t: accept flag exp %b got %b", $time,
                           want.accept, got.accept);
               if (got.ovl !== want.ovl)
                  $display("%0t: overlapped exp %b got %b", $time, want.ovl, got.ovl);
               if (got.conflict !== want.conflict)
                  $display("%0t: bank_conflict exp %b got %b", $time,
                           want.conflict, got.conflict);
               if (got.stall !== want.stall)
                  $display("%0t: stall cycles exp %0d got %0d", $time,
                           want.stall, got.stall);
               if (got !== want) fail_count++;
            end
         end
      end
   end

   // Sends one request beat; the prediction is queued when the beat is taken.
   // A fixed expectation, when given, is compared with the predictor too.
   task automatic send_beat(access_type a, bit has_fixed, timing_type fixed);
      timing_type t;
      req_tvalid <= 1'b1;
      req_tuser  <= a.func;
      req_tdata  <= {a.dcomp, a.lat, a.addr, a.now};
      do @(posedge clock); while (!req_tready);
      t = track_miss(a);
      if (has_fixed && t !== fixed) begin
         $display("%0t: table row exp %h predicted %h", $time, fixed, t);
         fail_count++;
      end
      pending_timing.push_back(t);
   endtask

   // Wait for all responses, then let the pipeline settle before a write.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_timing.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_MISS_SLOTS: slots_reg = val & 7'h7F;
         REG_NUM_BANKS:  banks_reg = val & 5'h1F;
         default:        stall_reg = val & 16'hFFFF;
      endcase
   endtask

   // Random beat: mostly accesses with a slowly advancing clock so misses
   // overlap and banks collide; a few wild values to reach the extremes.
   logic [47:0] sim_now;
   function automatic access_type rand_beat();
      access_type a;
      a.func = ($urandom_range(0, 5) == 0) ? FUNC_PROBE : FUNC_ACCESS;
      if ($urandom_range(0, 30) == 0) sim_now = 48'({$urandom, $urandom});
      else sim_now = sat_sum(sim_now, 48'($urandom_range(0, 40)));
      a.now = sim_now;
      a.addr = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom})
                                          : 48'($urandom_range(0, 4095));
      case ($urandom_range(0, 9))
         0: a.lat = '0;
         1: a.lat = 16'hFFFF;
         2: a.lat = 16'($urandom);
         default: a.lat = 16'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 5))
         0: a.dcomp = 48'({$urandom, $urandom});
         1: a.dcomp = sat_sum(a.now, 48'($urandom_range(1, 500)));
         2: a.dcomp = a.now;
         default: a.dcomp = '0;
      endcase
      return a;
   endfunction

   // Directed rows: extremes, both functions and each special case.
   typedef struct {
      access_type a;
      bit         has_fixed;
      timing_type fixed;
   } row_type;

   row_type     rows [$];
   timing_type  none;
   int unsigned cfg [3][3];

   function automatic access_type mk(logic f, logic [47:0] n, logic [47:0] ad,
                                     logic [15:0] l, logic [47:0] d);
      access_type x;
      x.func = f; x.now = n; x.addr = ad; x.lat = l; x.dcomp = d;
      return x;
   endfunction

   function automatic timing_type fx(int unsigned e, logic [47:0] c, int unsigned n,
                                     bit acc);
      timing_type t;
      t = '0;
      t.eff_lat = 17'(e); t.comp = c; t.count = 7'(n); t.accept = acc;
      return t;
   endfunction

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      hold_rsp   = 1'b0;
      hold_done  = 1'b0;
      sim_now    = 48'd1000;
      none       = '0;
      reset_tracker();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset: empty table, probe reports zero and accepts.
      rows.push_back('{mk(FUNC_PROBE, '0, '0, '0, '0), 1'b1, fx(0, '0, 0, 1'b1)});
      // First miss, legacy completion, no peers.
      rows.push_back('{mk(FUNC_ACCESS, 48'd100, '0, 16'd40, '0), 1'b1,
                       fx(40, 48'd140, 1, 1'b1)});
      // Overlapping miss with downstream completion after the item cycle.
      rows.push_back('{mk(FUNC_ACCESS, 48'd101, 48'd64, 16'd40, 48'd500), 1'b0, none});
      // Zero latency: nothing recorded.
      rows.push_back('{mk(FUNC_ACCESS, 48'd102, 48'd128, '0, '0), 1'b0, none});
      // Discount floor of one.
      rows.push_back('{mk(FUNC_ACCESS, 48'd103, '0, 16'd1, '0), 1'b0, none});
      rows.push_back('{mk(FUNC_PROBE, 48'd140, '0, '0, '0), 1'b0, none});
      // Expiry past everything.
      rows.push_back('{mk(FUNC_PROBE, 48'd100000, '0, '0, '0), 1'b1,
                       fx(0, '0, 0, 1'b1)});
      // Saturating completion at the top of the cycle range.
      rows.push_back('{mk(FUNC_ACCESS, CYC_MAX, CYC_MAX, 16'hFFFF, CYC_MAX), 1'b1,
                       fx(32'hFFFF, CYC_MAX, 1, 1'b1)});
      rows.push_back('{mk(FUNC_ACCESS, CYC_MAX, CYC_MAX, 16'hFFFF, '0), 1'b0, none});
      rows.push_back('{mk(FUNC_PROBE, CYC_MAX, '0, '0, '0), 1'b0, none});
      foreach (rows[i]) send_beat(rows[i].a, rows[i].has_fixed, rows[i].fixed);
      drain();

      // Conflict model on, then a full table with a single slot.
      write_reg(REG_NUM_BANKS, 4);
      write_reg(REG_BUSY_TIME, 50);
      rows.delete();
      rows.push_back('{mk(FUNC_PROBE, '0, '0, '0, '0), 1'b0, none});
      rows.push_back('{mk(FUNC_ACCESS, 48'd10, '0, 16'd20, '0), 1'b0, none});
      rows.push_back('{mk(FUNC_ACCESS, 48'd20, 48'd256, 16'd20, '0), 1'b0, none});
      rows.push_back('{mk(FUNC_ACCESS, 48'd30, 48'd64, 16'd20, '0), 1'b0, none});
      rows.push_back('{mk(FUNC_ACCESS, 48'd200, 48'd256, 16'd20, '0), 1'b0, none});
      rows.push_back('{mk(FUNC_ACCESS, CYC_MAX - 48'd10, 48'd512, 16'd5, '0), 1'b0,
                       none});
      rows.push_back('{mk(FUNC_ACCESS, CYC_MAX - 48'd5, 48'd512, 16'd5, '0), 1'b0,
                       none});
      foreach (rows[i]) send_beat(rows[i].a, 1'b0, none);
      drain();
      write_reg(REG_MISS_SLOTS, 1);
      send_beat(mk(FUNC_ACCESS, '0, '0, 16'd30, '0), 1'b0, none);
      send_beat(mk(FUNC_ACCESS, 48'd1, '0, 16'd30, '0), 1'b0, none);
      send_beat(mk(FUNC_PROBE, 48'd2, '0, '0, '0), 1'b0, none);
      drain();
      write_reg(REG_MISS_SLOTS, 0);
      send_beat(mk(FUNC_ACCESS, 48'd3, '0, 16'd30, '0), 1'b0, none);
      send_beat(mk(FUNC_PROBE, 48'd4, '0, '0, '0), 1'b0, none);
      drain();

      // Random phases over several register settings, extremes among them.
      cfg = '{'{64, 16, 65535}, '{8, 31, 7}, '{3, 1, 100}};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 3) begin
            write_reg(REG_MISS_SLOTS, cfg[ph][0]);
            write_reg(REG_NUM_BANKS, cfg[ph][1]);
            write_reg(REG_BUSY_TIME, cfg[ph][2]);
         end else begin
            write_reg(REG_MISS_SLOTS, $urandom_range(1, 127));
            write_reg(REG_NUM_BANKS, $urandom_range(0, 31));
            write_reg(REG_BUSY_TIME, $urandom_range(0, 3) == 0 ? 0
                                     : $urandom_range(1, 400));
         end
         for (int n = 0; n < 85;) begin
            int burst;
            burst = $urandom_range(1, 12);
            // Midway through one phase the receiver holds off for a long time.
            if (ph == 1 && n >= 40 && !hold_done) begin
               hold_done = 1'b1;
               fork
                  begin
                     hold_rsp = 1'b1;
                     repeat (600) @(posedge clock);
                     hold_rsp = 1'b0;
                  end
               join_none
            end
            for (int k = 0; k < burst && n < 85; k++, n++)
               send_beat(rand_beat(), 1'b0, none);
            if ($urandom_range(0, 2) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mot_pkg.sv
rtl/mot_ram.sv
rtl/mot_div.sv
rtl/miss_overlap_and_bank_conflict_timer.sv
test/miss_overlap_and_bank_conflict_timer_tb.sv
